[hdl/matrix3_inverse_fixed_macros.svh]
// Assertion helpers for the matrix inverse block.
`ifndef MATRIX3_INVERSE_FIXED_MACROS_SVH
`define MATRIX3_INVERSE_FIXED_MACROS_SVH

// Same-cycle implication, off during reset.
`define M3I_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define M3I_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Check what a reset cycle leaves behind.
`define M3I_ASSERT_RST(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) else $error(msg);

`endif

[hdl/m3i_pkg.sv]
package m3i_pkg;

    localparam int NUM_ELEM     = 9;
    localparam int THR_W        = 40;
    localparam int FRONT_STAGES = 7;

    localparam logic [THR_W-1:0] THR_RESET = 40'd281474977;

    // Cofactor i = m[a]*m[b] - m[c]*m[d], columns a, b, c, d
    localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic ovf;
        logic neg;
    } lane_flags_t;

endpackage

[hdl/matrix3_inverse_fixed.sv]
// The cofactor and determinant math runs in the front stages, followed by ELEM_WIDTH + 3
//   divider stages (one quotient bit per stage in each of nine lanes) and one output stage.
// Throughput: one matrix per cycle while not stalled; each stage moves on when the output
//   is taken or when it or a later stage is empty.
// Reset: synchronous, active low; clears all stage valids and loads the
//   singular threshold with its default (about 1e-6).
module matrix3_inverse_fixed #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [m3i_pkg::THR_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2, in_r2c0, in_r2c1, in_r2c2
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2
    output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular
    output logic [0:0]                    m_tuser
);

    localparam int E      = ELEM_WIDTH;
    localparam int N      = m3i_pkg::NUM_ELEM;
    localparam int DATA_W = ((9*ELEM_WIDTH+7)/8)*8;
    localparam int AW     = 2*E + 1;
    localparam int MW     = 3*E;
    localparam int FS     = m3i_pkg::FRONT_STAGES;
    localparam int LS     = E + 3;
    localparam int P      = FS + LS + 1;

    logic [m3i_pkg::THR_W-1:0] thr_reg;
    logic [P-1:0]              v_reg;
    logic [P-1:0]              v_next;
    logic [P-1:0]              adv;
    logic [P-1:0]              low_mask;

    logic signed [E-1:0]  mat     [N];
    logic signed [AW-1:0] adj     [N];
    logic [MW-1:0]        det_mag;
    logic                 det_neg;
    logic                 det_sing;

    logic [LS-2:0][MW-1:0] dm_reg;
    logic [LS-1:0]         sg_reg;
    logic [LS-1:0][MW-1:0] d_in;

    logic [E:0]           lane_q  [N];
    m3i_pkg::lane_flags_t lane_fl [N];
    logic signed [E-1:0]  res     [N];
    logic                 res_sing;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= m3i_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // A stage advances when the output is taken or any stage at or after it is empty
    always_comb begin
        for (int i = 0; i < P; i++) begin
            low_mask = (P'(1) << i) - P'(1);
            adv[i]   = m_tready || ((v_reg | low_mask) != '1);
        end
        v_next[0] = adv[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < P; i++) begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Unpack the matrix
    always_comb begin
        for (int i = 0; i < N; i++) mat[i] = $signed(s_tdata[i*E +: E]);
    end

    m3i_front #(.ELEM_WIDTH(E)) u_front (
        .aclk       (aclk),
        .adv        (adv[FS-1:0]),
        .mat_i      (mat),
        .thr_i      (thr_reg),
        .adj_o      (adj),
        .det_mag_o  (det_mag),
        .det_neg_o  (det_neg),
        .singular_o (det_sing)
    );

    // Shared divisor and singular flag, kept in step with the lanes
    always_ff @(posedge aclk) begin
        if (adv[FS]) begin
            dm_reg[0] <= det_mag;
            sg_reg[0] <= det_sing;
        end
        for (int j = 1; j < LS; j++) begin
            if (adv[FS+j]) begin
                sg_reg[j] <= sg_reg[j-1];
                if (j < LS - 1) dm_reg[j] <= dm_reg[j-1];
            end
        end
    end

    always_comb begin
        d_in[0] = det_mag;
        for (int j = 1; j < LS; j++) d_in[j] = dm_reg[j-1];
    end

    for (genvar l = 0; l < N; l++) begin : g_lane
        m3i_lane #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .adv     (adv[FS+LS-1:FS]),
            .adj_i   (adj[l]),
            .d_neg_i (det_neg),
            .d_mag_i (d_in),
            .q_o     (lane_q[l]),
            .flags_o (lane_fl[l])
        );
    end

    m3i_merge #(.ELEM_WIDTH(E)) u_merge (
        .aclk    (aclk),
        .adv     (adv[P-1]),
        .q_i     (lane_q),
        .flags_i (lane_fl),
        .sing_i  (sg_reg[LS-1]),
        .out_o   (res),
        .sing_o  (res_sing)
    );

    // Pack the result
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < N; i++) m_tdata[i*E +: E] = res[i];
    end

    assign s_tready = adv[0];
    assign m_tvalid = v_reg[P-1];
    assign m_tuser  = res_sing;

endmodule

[hdl/m3i_front.sv]
module m3i_front #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic [m3i_pkg::FRONT_STAGES-1:0]     adv,
    input  logic signed [ELEM_WIDTH-1:0]         mat_i [m3i_pkg::NUM_ELEM],
    input  logic [m3i_pkg::THR_W-1:0]            thr_i,
    output logic signed [2*ELEM_WIDTH:0]         adj_o [m3i_pkg::NUM_ELEM],
    output logic [3*ELEM_WIDTH-1:0]              det_mag_o,
    output logic                                 det_neg_o,
    output logic                                 singular_o
);

    localparam int E  = ELEM_WIDTH;
    localparam int N  = m3i_pkg::NUM_ELEM;
    localparam int PW = 2*E;
    localparam int AW = 2*E + 1;
    localparam int TW = 2*E + 1;
    localparam int DW = 3*E + 1;
    localparam int MW = 3*E;

    logic signed [E-1:0]  m_reg    [N];
    logic signed [PW-1:0] p_reg    [2*N];
    logic signed [E-1:0]  r0a_reg  [3];
    logic signed [E-1:0]  r0b_reg  [3];
    logic signed [AW-1:0] adj2_reg [N];
    logic signed [AW-1:0] adj3_reg [N];
    logic signed [AW-1:0] adj4_reg [N];
    logic signed [AW-1:0] adj5_reg [N];
    logic signed [AW-1:0] adj6_reg [N];
    logic signed [TW-1:0] pl_reg   [3];
    logic signed [TW-1:0] ph_reg   [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;
    logic [MW-1:0]        mag_reg;
    logic                 neg_reg;
    logic                 sing_reg;

    logic signed [PW-1:0] prod_c [2*N];
    logic signed [AW-1:0] cof_c  [N];
    logic signed [TW-1:0] pl_c   [3];
    logic signed [TW-1:0] ph_c   [3];
    logic signed [DW-1:0] term_c [3];
    logic signed [DW-1:0] det_c;
    logic signed [DW-1:0] abs_c;

    // Pairwise products of the cofactor terms
    always_comb begin
        for (int i = 0; i < N; i++) begin
            prod_c[2*i]   = PW'(m_reg[m3i_pkg::COF_IDX[i][0]])
                          * PW'(m_reg[m3i_pkg::COF_IDX[i][1]]);
            prod_c[2*i+1] = PW'(m_reg[m3i_pkg::COF_IDX[i][2]])
                          * PW'(m_reg[m3i_pkg::COF_IDX[i][3]]);
        end
    end

    // Cofactors
    always_comb begin
        for (int i = 0; i < N; i++) begin
            cof_c[i] = AW'(p_reg[2*i]) - AW'(p_reg[2*i+1]);
        end
    end

    // Row-0 partial products, cofactor split into low and high halves
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pl_c[j] = TW'(r0b_reg[j]) * TW'($signed({1'b0, adj2_reg[3*j][E-1:0]}));
            ph_c[j] = TW'(r0b_reg[j]) * TW'($signed(adj2_reg[3*j][AW-1:E]));
        end
    end

    // Recombine halves, sum the expansion, take magnitude
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            term_c[j] = (DW'(ph_reg[j]) <<< E) + DW'(pl_reg[j]);
        end
        det_c = term_reg[0] + term_reg[1] + term_reg[2];
        abs_c = det_reg[DW-1] ? -det_reg : det_reg;
    end

    // Advance each stage when it may move on
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            m_reg <= mat_i;
        end
        if (adv[1]) begin
            p_reg <= prod_c;
            for (int j = 0; j < 3; j++) r0a_reg[j] <= m_reg[j];
        end
        if (adv[2]) begin
            adj2_reg <= cof_c;
            r0b_reg  <= r0a_reg;
        end
        if (adv[3]) begin
            pl_reg   <= pl_c;
            ph_reg   <= ph_c;
            adj3_reg <= adj2_reg;
        end
        if (adv[4]) begin
            term_reg <= term_c;
            adj4_reg <= adj3_reg;
        end
        if (adv[5]) begin
            det_reg  <= det_c;
            adj5_reg <= adj4_reg;
        end
        if (adv[6]) begin
            mag_reg  <= abs_c[MW-1:0];
            neg_reg  <= det_reg[DW-1];
            sing_reg <= (det_reg == '0) || (abs_c[MW-1:0] < MW'(thr_i));
            adj6_reg <= adj5_reg;
        end
    end

    assign adj_o      = adj6_reg;
    assign det_mag_o  = mag_reg;
    assign det_neg_o  = neg_reg;
    assign singular_o = sing_reg;

endmodule

[hdl/m3i_lane.sv]
module m3i_lane #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       aclk,
    input  logic [ELEM_WIDTH+2:0]                      adv,
    input  logic signed [2*ELEM_WIDTH:0]               adj_i,
    input  logic                                       d_neg_i,
    input  logic [ELEM_WIDTH+2:0][3*ELEM_WIDTH-1:0]    d_mag_i,
    output logic [ELEM_WIDTH:0]                        q_o,
    output m3i_pkg::lane_flags_t                       flags_o
);

    localparam int E   = ELEM_WIDTH;
    localparam int S   = 2*FRAC_BITS;
    localparam int AW  = 2*E + 1;
    localparam int AM  = 2*E;
    localparam int MW  = 3*E;
    localparam int NW  = AM + S;
    localparam int DX  = MW + E;
    localparam int RW  = ((NW > DX) ? NW : DX) + 1;
    localparam int LS  = E + 3;

    logic [AM-1:0]        amag_reg;
    logic [RW-1:0]        rem_reg [E+1];
    logic [E-1:0]         q_reg   [E+1];
    m3i_pkg::lane_flags_t fl_reg  [LS];
    logic [E:0]           qo_reg;

    logic signed [AW-1:0] neg_adj_c;
    logic [RW-1:0]        num_c;
    logic [RW-1:0]        lim_c;
    logic [RW-1:0]        rem_nx [E];
    logic [E-1:0]         q_nx   [E];
    logic [RW-1:0]        dk_c   [E];
    logic                 ge_c   [E];
    logic                 rnd_c;

    // Magnitude of the cofactor, shifted numerator, overflow bound
    always_comb begin
        neg_adj_c = -adj_i;
        num_c     = RW'(amag_reg) << S;
        lim_c     = RW'(d_mag_i[1]) << E;
    end

    // One restoring-division step per stage, most significant bit first
    always_comb begin
        for (int b = 0; b < E; b++) begin
            dk_c[b]   = RW'(d_mag_i[b+2]) << (E - 1 - b);
            ge_c[b]   = rem_reg[b] >= dk_c[b];
            rem_nx[b] = ge_c[b] ? rem_reg[b] - dk_c[b] : rem_reg[b];
            q_nx[b]   = q_reg[b] | (E'(ge_c[b]) << (E - 1 - b));
        end
        rnd_c = (rem_reg[E] << 1) >= RW'(d_mag_i[E+2]);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            amag_reg      <= adj_i[AW-1] ? neg_adj_c[AM-1:0] : adj_i[AM-1:0];
            fl_reg[0].neg <= adj_i[AW-1] ^ d_neg_i;
            fl_reg[0].ovf <= 1'b0;
        end
        if (adv[1]) begin
            rem_reg[0]    <= num_c;
            q_reg[0]      <= '0;
            fl_reg[1].neg <= fl_reg[0].neg;
            fl_reg[1].ovf <= num_c >= lim_c;
        end
        for (int b = 0; b < E; b++) begin
            if (adv[b+2]) begin
                rem_reg[b+1] <= rem_nx[b];
                q_reg[b+1]   <= q_nx[b];
                fl_reg[b+2]  <= fl_reg[b+1];
            end
        end
        // Round half away from zero on the magnitude
        if (adv[E+2]) begin
            qo_reg       <= (E+1)'(q_reg[E]) + (E+1)'(rnd_c);
            fl_reg[E+2]  <= fl_reg[E+1];
        end
    end

    assign q_o     = qo_reg;
    assign flags_o = fl_reg[E+2];

endmodule

[hdl/m3i_merge.sv]
module m3i_merge #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         adv,
    input  logic [ELEM_WIDTH:0]          q_i     [m3i_pkg::NUM_ELEM],
    input  m3i_pkg::lane_flags_t         flags_i [m3i_pkg::NUM_ELEM],
    input  logic                         sing_i,
    output logic signed [ELEM_WIDTH-1:0] out_o   [m3i_pkg::NUM_ELEM],
    output logic                         sing_o
);

    localparam int E = ELEM_WIDTH;
    localparam int N = m3i_pkg::NUM_ELEM;

    localparam logic [E:0]   HALF  = (E+1)'(1) << (E - 1);
    localparam logic [E:0]   QMAX  = HALF - (E+1)'(1);
    localparam logic [E-1:0] S_MAX = QMAX[E-1:0];
    localparam logic [E-1:0] S_MIN = HALF[E-1:0];

    logic [E-1:0] out_next [N];
    logic         sat_c    [N];

    // Saturate, apply sign, zero everything when singular
    always_comb begin
        for (int i = 0; i < N; i++) begin
            sat_c[i] = flags_i[i].ovf
                     || (flags_i[i].neg ? (q_i[i] > HALF) : (q_i[i] > QMAX));
            if (sing_i) begin
                out_next[i] = '0;
            end else if (sat_c[i]) begin
                out_next[i] = flags_i[i].neg ? S_MIN : S_MAX;
            end else begin
                out_next[i] = flags_i[i].neg ? -q_i[i][E-1:0] : q_i[i][E-1:0];
            end
        end
    end

    logic signed [E-1:0] out_reg [N];
    logic                sing_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N; i++) out_reg[i] <= $signed(out_next[i]);
            sing_reg <= sing_i;
        end
    end

    assign out_o  = out_reg;
    assign sing_o = sing_reg;

endmodule

[hdl/m3i_checker.sv]
`include "matrix3_inverse_fixed_macros.svh"

module m3i_checker #(
    parameter int DATA_W = 288
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [0:0]        m_tuser
);

    // Held result stays offered
    `M3I_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // Held result keeps its payload
    `M3I_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Singular results carry zero elements
    `M3I_ASSERT_NOW(a_sing_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0, "singular result with nonzero data")

    // An empty output stage lets the whole pipeline move
    `M3I_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

    // Reset empties the pipeline
    `M3I_ASSERT_RST(a_reset_empty, aclk, aresetn, !m_tvalid, "result offered after reset")

endmodule

bind matrix3_inverse_fixed m3i_checker #(.DATA_W(DATA_W)) u_m3i_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb_matrix3_inverse_fixed.sv]
`timescale 1ns / 100ps

module tb_matrix3_inverse_fixed;

    localparam int EW        = 32;
    localparam int N_RANDOM  = 600;
    localparam int HOLD_LEN  = 300;
    localparam int IDLE_MAX  = 5000;
    localparam int DRAIN     = 60;
    localparam logic [EW-1:0] ONE_Q    = 32'h0001_0000;
    localparam logic [EW-1:0] POS_SAT  = 32'h7FFF_FFFF;
    localparam logic [EW-1:0] NEG_SAT  = 32'h8000_0000;
    localparam logic [m3i_pkg::THR_W-1:0] THR_MAX = '1;

    typedef logic [8:0][EW-1:0] mat_t;
    typedef struct packed {
        logic          sing;
        logic [8:0][EW-1:0] e;
    } inv_t;
    typedef struct {
        logic [m3i_pkg::THR_W-1:0] thr;
        mat_t m;
        bit   typed;
        inv_t want;
    } vec_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [m3i_pkg::THR_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [9*EW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [9*EW-1:0] m_tdata;
    logic [0:0] m_tuser;

    inv_t inverse_q[$];
    logic [m3i_pkg::THR_W-1:0] thr_now;
    int n_err;
    int n_sent;
    int n_checked;
    int n_singular;
    int n_saturated;
    int burst_left;
    bit hold_req;
    vec_t dir_tab[$];

    matrix3_inverse_fixed u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Exact inverse: adjugate scaled by 2^32 over det, round half away, saturate
    function automatic inv_t invert(mat_t m, logic [m3i_pkg::THR_W-1:0] thr);
        logic signed [127:0] a[9];
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic [127:0] mag, num, q, r;
        bit neg;
        inv_t res;
        for (int i = 0; i < 9; i++) a[i] = {{96{m[i][EW-1]}}, m[i]};
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        mag = det[127] ? -det : det;
        res = '0;
        if (det == 0 || mag < {88'd0, thr}) begin
            res.sing = 1'b1;
            return res;
        end
        for (int i = 0; i < 9; i++) begin
            neg = adj[i][127] ^ det[127];
            num = (adj[i][127] ? -adj[i] : adj[i]) << 32;
            q = num / mag;
            r = num % mag;
            if ((r << 1) >= mag) q = q + 1;
            if (neg) begin
                if (q > 128'h8000_0000) q = 128'h8000_0000;
                res.e[i] = -q[EW-1:0];
            end else begin
                if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
                res.e[i] = q[EW-1:0];
            end
        end
        return res;
    endfunction

    task automatic report(string what, logic [EW-1:0] got, logic [EW-1:0] want);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, n_checked, got, want);
        n_err++;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        inv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                $display("unexpected result transfer: %h", m_tdata);
                n_err++;
            end else begin
                want = inverse_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[i*EW +: EW] !== want.e[i])
                        report($sformatf("r%0dc%0d", i / 3, i % 3),
                               m_tdata[i*EW +: EW], want.e[i]);
                if (m_tuser[0] !== want.sing)
                    report("singular", {31'd0, m_tuser[0]}, {31'd0, want.sing});
                if (want.sing) n_singular++;
                for (int i = 0; i < 9; i++)
                    if (want.e[i] == POS_SAT || want.e[i] == NEG_SAT) begin
                        n_saturated++;
                        break;
                    end
            end
            n_checked++;
        end
    end

    // Abort when neither side has moved for too long
    always @(posedge aclk) begin
        int idle;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle = 0;
        else if (++idle >= IDLE_MAX) begin
            $display("timeout: no transfer for %0d cycles", IDLE_MAX);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stall pattern with ready stretches and one long hold-off
    initial begin
        int mode;
        int left;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(5, 80);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // Write the threshold once the pipeline has drained
    task automatic set_threshold(logic [m3i_pkg::THR_W-1:0] v);
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        thr_now = v;
        cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    // Offer one matrix, hold until the transfer, then maybe pause between bursts
    task automatic send(mat_t m, bit typed, inv_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        do @(posedge aclk); while (!s_tready);
        inverse_q.push_back(typed ? want : invert(m, thr_now));
        n_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic mat_t diag(logic [EW-1:0] d);
        mat_t m = '0;
        m[0] = d;
        m[4] = d;
        m[8] = d;
        return m;
    endfunction

    function automatic logic [EW-1:0] small_elem();
        return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            m[i] = (kind < 3) ? $urandom : small_elem();
        if (kind == 8) begin
            // dependent rows, with a slight nudge so some land near the threshold
            for (int i = 0; i < 3; i++)
                m[6+i] = m[i] + m[3+i] + $urandom_range(0, 3) - 1;
        end else if (kind == 9) begin
            for (int i = 0; i < 9; i++)
                m[i] = (i % 4 == 0) ? $urandom_range(1, 32'h200) : $urandom_range(0, 3);
        end
        return m;
    endfunction

    function automatic void add_row(logic [m3i_pkg::THR_W-1:0] thr, mat_t m,
                                    bit typed, inv_t want);
        vec_t v;
        v.thr = thr;
        v.m = m;
        v.typed = typed;
        v.want = want;
        dir_tab.push_back(v);
    endfunction

    initial begin
        inv_t w;
        mat_t m;
        logic [m3i_pkg::THR_W-1:0] thr_set[5];
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_req   = 1'b0;
        thr_now    = m3i_pkg::THR_RESET;
        n_err      = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_singular = 0;
        n_saturated = 0;
        burst_left = 0;

        // Directed rows: expectation typed in where it is obvious
        w = '0;
        w.e = diag(ONE_Q);
        add_row(m3i_pkg::THR_RESET, diag(ONE_Q), 1, w);
        w = '0;
        w.sing = 1'b1;
        add_row(m3i_pkg::THR_RESET, '0, 1, w);
        add_row(m3i_pkg::THR_RESET, diag(32'd1), 1, w);
        add_row(m3i_pkg::THR_RESET, {9{POS_SAT}}, 1, w);
        add_row(m3i_pkg::THR_RESET, {9{NEG_SAT}}, 1, w);
        add_row(m3i_pkg::THR_RESET, diag(NEG_SAT), 0, '0);
        add_row(m3i_pkg::THR_RESET, diag(POS_SAT), 0, '0);
        add_row(m3i_pkg::THR_RESET, diag(32'h0000_1000), 0, '0);
        add_row(m3i_pkg::THR_RESET, diag(-ONE_Q), 0, '0);
        m = diag(ONE_Q);
        m[1] = POS_SAT;
        m[5] = NEG_SAT;
        m[6] = 32'h0002_8000;
        add_row(m3i_pkg::THR_RESET, m, 0, '0);
        m = {POS_SAT, NEG_SAT, 32'd1, 32'hFFFF_FFFF, POS_SAT, 32'd0,
             NEG_SAT, 32'd7, POS_SAT};
        add_row(m3i_pkg::THR_RESET, m, 0, '0);
        // zero threshold: tiny nonzero determinant saturates, zero stays singular
        w = '0;
        w.e = diag(POS_SAT);
        add_row('0, diag(32'd1), 1, w);
        w = '0;
        w.e = diag(NEG_SAT);
        add_row('0, diag(32'hFFFF_FFFF), 1, w);
        w = '0;
        w.sing = 1'b1;
        add_row('0, '0, 1, w);
        // row 1 repeats row 0
        m = diag(32'd1);
        m[3] = 32'd1;
        m[4] = 32'd0;
        add_row('0, m, 1, w);
        add_row('0, diag(32'd3), 0, '0);
        // threshold at the boundary and at the top
        add_row(40'd1 << 36, diag(32'h0000_1000), 0, '0);
        add_row((40'd1 << 36) + 40'd1, diag(32'h0000_1000), 0, '0);
        add_row(THR_MAX, diag(ONE_Q), 0, '0);
        add_row(THR_MAX, diag(32'h0100_0000), 0, '0);
        add_row(THR_MAX, {9{NEG_SAT}}, 0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        foreach (dir_tab[i]) begin
            if (dir_tab[i].thr != thr_now || i == 0)
                set_threshold(dir_tab[i].thr);
            send(dir_tab[i].m, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random part over several thresholds, with one long receiver stall
        thr_set = '{m3i_pkg::THR_RESET, '0, THR_MAX, 40'd1,
                    m3i_pkg::THR_W'({$urandom, $urandom})};
        foreach (thr_set[p]) begin
            set_threshold(thr_set[p]);
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                if (p == 1 && k == 20) hold_req = 1'b1;
                send(rand_matrix(), 0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (inverse_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("sent %0d matrices over %0d threshold settings; %0d results checked",
                 n_sent, 5, n_checked);
        $display("%0d singular, %0d with a saturated element, %0d mismatches",
                 n_singular, n_saturated, n_err);
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
